### design/fmpf_pkg.sv
// fmpf_pkg: shared types and constants for the first-match packet filter.
// Holds the input and result word structs, the rule entry layout and protocol codes.
// No dependencies.
package fmpf_pkg;

    localparam int RULE_COUNT_DEFAULT = 512;

    localparam logic FUNC_WRITE    = 1'b0;
    localparam logic FUNC_CLASSIFY = 1'b1;

    localparam logic [1:0] DECIDED_UNFILTERED = 2'd0;
    localparam logic [1:0] DECIDED_RULE       = 2'd1;
    localparam logic [1:0] DECIDED_DEFAULT    = 2'd2;

    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  PROTO_ICMP     = 8'd1;
    localparam logic [7:0]  PROTO_TCP      = 8'd6;
    localparam logic [7:0]  PROTO_UDP      = 8'd17;

    // Ethernet header, plus Ethernet and minimal IPv4 header
    localparam logic [15:0] ETH_LEN      = 16'd14;
    localparam logic [15:0] ETH_IPV4_LEN = 16'd34;
    // Ethernet header plus TCP or UDP header
    localparam logic [6:0]  ETH_TCP_LEN  = 7'd34;
    localparam logic [6:0]  ETH_UDP_LEN  = 7'd22;

    typedef struct packed {
        logic        func;
        logic [8:0]  rule_index;
        logic [7:0]  protocol;
        logic [31:0] address;
        logic [31:0] mask;
        logic [15:0] port;
        logic [15:0] port_high;
        logic [3:0]  rule_flags;
        logic [15:0] ether_type;
        logic [3:0]  header_words;
        logic [15:0] captured_length;
    } fmpf_in_t;

    typedef struct packed {
        logic       drop;
        logic [1:0] decided_by;
        logic [8:0] matched_slot;
    } fmpf_out_t;

    typedef struct packed {
        logic        accept;
        logic        range;
        logic        enabled;
        logic [15:0] port_high;
        logic [15:0] port_low;
        logic [7:0]  protocol;
        logic [31:0] mask;
        logic [31:0] address;
    } fmpf_rule_t;

    localparam int RULE_W = $bits(fmpf_rule_t);

endpackage

### design/first_match_packet_filter.sv
// first_match_packet_filter: rule table with a first-match scan over one shared comparator.
// Depends on fmpf_pkg and fmpf_ram.
//
// After reset the block sweeps every used-flag RAM slot and takes no word meanwhile; the
// default_accept register can be written at any time. A write word leaves the block idle.
// A classify word that passes unfiltered has its result registered, then loaded into the
// output register. A scanned classify word reads one rule per cycle from the rule RAM
// through a single match unit, stopping at the first matching slot or, past the last slot,
// letting the default policy decide; the block takes no new word until the result is loaded
// into the output register, which holds one result while the next word is accepted.
module first_match_packet_filter #(
    parameter int RULE_COUNT = fmpf_pkg::RULE_COUNT_DEFAULT
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  fmpf_pkg::fmpf_in_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output fmpf_pkg::fmpf_out_t m_data,
    input  logic               cfg_wr_en,
    input  logic               cfg_wr_data
);

    import fmpf_pkg::*;

    localparam int SLOT_W = (RULE_COUNT > 1) ? $clog2(RULE_COUNT) : 1;
    localparam int CNT_W  = $clog2(RULE_COUNT + 1);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_SCAN  = 2'd2;
    localparam logic [1:0] ST_HOLD  = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [SLOT_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic [CNT_W-1:0]  issue_cnt_reg, issue_cnt_next;
    logic              eval_valid_reg, eval_valid_next;
    logic [SLOT_W-1:0] eval_slot_reg, eval_slot_next;
    logic              default_accept_reg;
    logic              m_valid_reg, m_valid_next;
    fmpf_out_t         m_data_reg, m_data_next;
    fmpf_out_t         res_reg, res_next;
    logic [7:0]        pkt_proto_reg, pkt_proto_next;
    logic [31:0]       pkt_addr_reg, pkt_addr_next;
    logic [15:0]       pkt_port_reg, pkt_port_next;
    logic              pkt_icmp_reg, pkt_icmp_next;

    logic              in_accept;
    logic              out_free;
    logic              wr_item;
    logic [SLOT_W+8:0] idx_wide;
    logic [SLOT_W+8:0] slot_wide;
    logic [SLOT_W-1:0] wr_addr;
    logic              unfiltered;
    logic [6:0]        tcp_need, udp_need;
    logic              is_tcp, is_udp, is_icmp;

    logic              used_wr_en;
    logic [SLOT_W-1:0] used_wr_addr;
    logic              used_wr_data;
    logic              used_q;
    logic              rd_en;
    logic [SLOT_W-1:0] rd_addr;
    logic [RULE_W-1:0] rule_rd_data;
    fmpf_rule_t        rule_q;
    fmpf_rule_t        rule_wr;
    logic              proto_ok, addr_ok, port_ok, rule_hit;

    assign s_ready   = (state_reg == ST_IDLE);
    assign in_accept = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    assign idx_wide  = (SLOT_W + 9)'(s_data.rule_index);
    assign wr_addr   = idx_wide[SLOT_W-1:0];
    assign wr_item   = in_accept && (s_data.func == FUNC_WRITE)
                       && ({23'd0, s_data.rule_index} < 32'(RULE_COUNT));
    assign slot_wide = (SLOT_W + 9)'(eval_slot_reg);

    assign rule_wr.accept    = s_data.rule_flags[3];
    assign rule_wr.range     = s_data.rule_flags[2];
    assign rule_wr.enabled   = s_data.rule_flags[1];
    assign rule_wr.port_high = s_data.port_high;
    assign rule_wr.port_low  = s_data.port;
    assign rule_wr.protocol  = s_data.protocol;
    assign rule_wr.mask      = s_data.mask;
    assign rule_wr.address   = s_data.address;

    // sweep the used flags after reset, then take rule writes
    assign used_wr_en   = (state_reg == ST_CLEAR) || wr_item;
    assign used_wr_addr = (state_reg == ST_CLEAR) ? clr_cnt_reg : wr_addr;
    assign used_wr_data = (state_reg == ST_CLEAR) ? 1'b0 : s_data.rule_flags[0];

    assign rd_en   = (state_reg == ST_SCAN) && (issue_cnt_reg < CNT_W'(RULE_COUNT));
    assign rd_addr = issue_cnt_reg[SLOT_W-1:0];

    fmpf_ram #(
        .WIDTH (1),
        .DEPTH (RULE_COUNT)
    ) u_used_ram (
        .aclk    (aclk),
        .wr_en   (used_wr_en),
        .wr_addr (used_wr_addr),
        .wr_data (used_wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (used_q)
    );

    fmpf_ram #(
        .WIDTH (RULE_W),
        .DEPTH (RULE_COUNT)
    ) u_rule_ram (
        .aclk    (aclk),
        .wr_en   (wr_item),
        .wr_addr (wr_addr),
        .wr_data (rule_wr),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rule_rd_data)
    );

    assign rule_q = fmpf_rule_t'(rule_rd_data);

    // header checks on the incoming word
    assign is_tcp   = (s_data.protocol == PROTO_TCP);
    assign is_udp   = (s_data.protocol == PROTO_UDP);
    assign is_icmp  = (s_data.protocol == PROTO_ICMP);
    assign tcp_need = ETH_TCP_LEN + {1'b0, s_data.header_words, 2'b00};
    assign udp_need = ETH_UDP_LEN + {1'b0, s_data.header_words, 2'b00};

    always_comb begin
        unfiltered = 1'b0;
        priority if (s_data.captured_length < ETH_LEN) begin
            unfiltered = 1'b1;
        end else if (s_data.ether_type != ETHERTYPE_IPV4) begin
            unfiltered = 1'b1;
        end else if (s_data.captured_length < ETH_IPV4_LEN) begin
            unfiltered = 1'b1;
        end else if (is_tcp) begin
            unfiltered = ({9'd0, tcp_need} > s_data.captured_length);
        end else if (is_udp) begin
            unfiltered = ({9'd0, udp_need} > s_data.captured_length);
        end else if (!is_icmp) begin
            unfiltered = 1'b1;
        end else begin
            unfiltered = 1'b0;
        end
    end

    // shared match unit on the registered rule read
    assign proto_ok = (rule_q.protocol == 8'd0) || (rule_q.protocol == pkt_proto_reg);
    assign addr_ok  = (rule_q.address == 32'd0)
                      || ((pkt_addr_reg & rule_q.mask) == (rule_q.address & rule_q.mask));

    always_comb begin
        if (pkt_icmp_reg) begin
            port_ok = 1'b1;
        end else if (rule_q.range) begin
            port_ok = (pkt_port_reg >= rule_q.port_low) && (pkt_port_reg <= rule_q.port_high);
        end else begin
            port_ok = (rule_q.port_low == 16'd0) || (rule_q.port_low == pkt_port_reg);
        end
    end

    assign rule_hit = eval_valid_reg && used_q && rule_q.enabled && proto_ok && addr_ok && port_ok;

    always_comb begin
        state_next      = state_reg;
        clr_cnt_next    = clr_cnt_reg;
        issue_cnt_next  = issue_cnt_reg;
        eval_valid_next = 1'b0;
        eval_slot_next  = eval_slot_reg;
        res_next        = res_reg;
        pkt_proto_next  = pkt_proto_reg;
        pkt_addr_next   = pkt_addr_reg;
        pkt_port_next   = pkt_port_reg;
        pkt_icmp_next   = pkt_icmp_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_data_next     = m_data_reg;

        unique case (state_reg)
            ST_CLEAR: begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == SLOT_W'(RULE_COUNT - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_accept && (s_data.func == FUNC_CLASSIFY)) begin
                    pkt_proto_next = s_data.protocol;
                    pkt_addr_next  = s_data.address;
                    pkt_port_next  = is_icmp ? 16'd0 : s_data.port;
                    pkt_icmp_next  = is_icmp;
                    issue_cnt_next = '0;
                    if (unfiltered) begin
                        res_next.drop         = 1'b0;
                        res_next.decided_by   = DECIDED_UNFILTERED;
                        res_next.matched_slot = 9'd0;
                        state_next            = ST_HOLD;
                    end else begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (rd_en) begin
                    issue_cnt_next  = issue_cnt_reg + 1'b1;
                    eval_valid_next = 1'b1;
                    eval_slot_next  = rd_addr;
                end
                if (rule_hit) begin
                    res_next.drop         = !rule_q.accept;
                    res_next.decided_by   = DECIDED_RULE;
                    res_next.matched_slot = slot_wide[8:0];
                    eval_valid_next       = 1'b0;
                    state_next            = ST_HOLD;
                end else if (!eval_valid_reg && !rd_en) begin
                    res_next.drop         = !default_accept_reg;
                    res_next.decided_by   = DECIDED_DEFAULT;
                    res_next.matched_slot = 9'd0;
                    state_next            = ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg          <= ST_CLEAR;
            clr_cnt_reg        <= '0;
            issue_cnt_reg      <= '0;
            eval_valid_reg     <= 1'b0;
            default_accept_reg <= 1'b0;
            m_valid_reg        <= 1'b0;
        end else begin
            state_reg      <= state_next;
            clr_cnt_reg    <= clr_cnt_next;
            issue_cnt_reg  <= issue_cnt_next;
            eval_valid_reg <= eval_valid_next;
            m_valid_reg    <= m_valid_next;
            if (cfg_wr_en) begin
                default_accept_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        eval_slot_reg <= eval_slot_next;
        res_reg       <= res_next;
        pkt_proto_reg <= pkt_proto_next;
        pkt_addr_reg  <= pkt_addr_next;
        pkt_port_reg  <= pkt_port_next;
        pkt_icmp_reg  <= pkt_icmp_next;
        m_data_reg    <= m_data_next;
    end

    a_slot_zero_unless_rule: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.decided_by == DECIDED_RULE || m_data.matched_slot == 9'd0))
        else $error("matched_slot nonzero without a matching rule");

    a_busy_after_classify: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_data.func == FUNC_CLASSIFY) |=> !s_ready)
        else $error("ready right after a classify word");

    a_unfiltered_passes: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.decided_by == DECIDED_UNFILTERED) |-> !m_data.drop)
        else $error("unfiltered packet marked for drop");

    a_scan_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> (issue_cnt_reg <= CNT_W'(RULE_COUNT)))
        else $error("scan counter past rule count");

    a_no_scan_read_outside_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        eval_valid_reg |-> $past(state_reg == ST_SCAN))
        else $error("rule evaluated outside a scan");

endmodule

### design/fmpf_ram.sv
// fmpf_ram: generic simple dual-port RAM, one write port and one registered read port.
// No dependencies.
module fmpf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### tb/tb_first_match_packet_filter.sv
// tb_first_match_packet_filter: self-checking testbench for the first-match packet filter.
// Drives rule writes and classify words, predicts each verdict, checks it on the result channel.
// Depends on fmpf_pkg and first_match_packet_filter.
`timescale 1ns / 100ps

module tb_first_match_packet_filter;
    import fmpf_pkg::*;

    localparam int RULE_COUNT     = RULE_COUNT_DEFAULT;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int MAX_REPORTS    = 10;

    localparam logic [3:0] RF_NONE    = 4'b0000;
    localparam logic [3:0] RF_USED    = 4'b0001;
    localparam logic [3:0] RF_ENABLED = 4'b0010;
    localparam logic [3:0] RF_RANGE   = 4'b0100;
    localparam logic [3:0] RF_ACCEPT  = 4'b1000;

    localparam logic [7:0] PROTO_ANY = 8'd0;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    fmpf_in_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    fmpf_out_t m_data;
    logic      cfg_wr_en = 1'b0;
    logic      cfg_wr_data = 1'b0;

    // predictor state
    bit         rule_used [RULE_COUNT];
    fmpf_rule_t rule_table [RULE_COUNT];
    logic       pred_default_accept = 1'b0;
    fmpf_out_t  expected_verdicts [$];

    logic [31:0] addr_pool [8];
    logic [15:0] port_pool [8];

    int burst_left = 0;
    int mismatches = 0;
    int idle_cycles = 0;
    int stall_mode = 0;
    int stall_left = 0;

    first_match_packet_filter #(
        .RULE_COUNT(RULE_COUNT)
    ) dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic bit rule_hits(input fmpf_rule_t r, input logic [7:0] proto,
                                     input logic [31:0] daddr, input logic [15:0] sport);
        if (!r.enabled) return 1'b0;
        if (r.protocol != PROTO_ANY && r.protocol != proto) return 1'b0;
        if (r.address != '0 && (daddr & r.mask) != (r.address & r.mask)) return 1'b0;
        if (proto != PROTO_ICMP) begin
            if (r.range) begin
                if (sport < r.port_low || sport > r.port_high) return 1'b0;
            end else if (r.port_low != '0 && r.port_low != sport) begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    function automatic fmpf_out_t predict_verdict(input fmpf_in_t w);
        fmpf_out_t   v;
        int unsigned hdr_bytes;
        logic [15:0] sport;
        bit          scan;
        v = '0;
        v.decided_by = DECIDED_UNFILTERED;
        hdr_bytes = 4 * w.header_words;
        sport = w.port;
        scan = 1'b1;
        if (w.captured_length < ETH_LEN) scan = 1'b0;
        else if (w.ether_type != ETHERTYPE_IPV4) scan = 1'b0;
        else if (w.captured_length < ETH_IPV4_LEN) scan = 1'b0;
        else if (w.protocol == PROTO_TCP) scan = (hdr_bytes + ETH_TCP_LEN <= w.captured_length);
        else if (w.protocol == PROTO_UDP) scan = (hdr_bytes + ETH_UDP_LEN <= w.captured_length);
        else if (w.protocol != PROTO_ICMP) scan = 1'b0;
        else sport = '0;
        if (!scan) return v;
        for (int s = 0; s < RULE_COUNT; s++) begin
            if (rule_used[s] && rule_hits(rule_table[s], w.protocol, w.address, sport)) begin
                v.drop = ~rule_table[s].accept;
                v.decided_by = DECIDED_RULE;
                v.matched_slot = s[8:0];
                return v;
            end
        end
        v.drop = ~pred_default_accept;
        v.decided_by = DECIDED_DEFAULT;
        return v;
    endfunction

    function automatic void apply_word(input fmpf_in_t w);
        fmpf_rule_t r;
        if (w.func == FUNC_WRITE) begin
            if (w.rule_index < RULE_COUNT) begin
                r.accept    = w.rule_flags[3];
                r.range     = w.rule_flags[2];
                r.enabled   = w.rule_flags[1];
                r.port_high = w.port_high;
                r.port_low  = w.port;
                r.protocol  = w.protocol;
                r.mask      = w.mask;
                r.address   = w.address;
                rule_table[w.rule_index] = r;
                rule_used[w.rule_index] = w.rule_flags[0];
            end
        end else begin
            expected_verdicts.push_back(predict_verdict(w));
        end
    endfunction

    task automatic send_word(input fmpf_in_t w);
        bit took;
        if (burst_left == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
            burst_left = $urandom_range(1, 24);
        end
        s_valid <= 1'b1;
        s_data <= w;
        do begin
            @(negedge aclk);
            took = s_ready;
            @(posedge aclk);
        end while (!took);
        apply_word(w);
        burst_left--;
    endtask

    // hold off until every verdict is in and the block has settled
    task automatic drain_verdicts();
        s_valid <= 1'b0;
        while (expected_verdicts.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic set_policy(input logic accept);
        drain_verdicts();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= accept;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        pred_default_accept = accept;
    endtask

    function automatic fmpf_in_t random_word();
        fmpf_in_t w;
        w.func            = 1'($urandom_range(0, 1));
        w.rule_index      = 9'($urandom);
        w.protocol        = 8'($urandom);
        w.address         = $urandom;
        w.mask            = $urandom;
        w.port            = 16'($urandom);
        w.port_high       = 16'($urandom);
        w.rule_flags      = 4'($urandom);
        w.ether_type      = 16'($urandom);
        w.header_words    = 4'($urandom);
        w.captured_length = 16'($urandom);
        return w;
    endfunction

    function automatic fmpf_in_t make_rule(input logic [8:0] slot, input logic [7:0] proto,
                                           input logic [31:0] addr, input logic [31:0] mask,
                                           input logic [15:0] lo, input logic [15:0] hi,
                                           input logic [3:0] flags);
        fmpf_in_t w;
        w = random_word();
        w.func = FUNC_WRITE;
        w.rule_index = slot;
        w.protocol = proto;
        w.address = addr;
        w.mask = mask;
        w.port = lo;
        w.port_high = hi;
        w.rule_flags = flags;
        return w;
    endfunction

    function automatic fmpf_in_t make_packet(input logic [7:0] proto, input logic [31:0] daddr,
                                             input logic [15:0] sport, input logic [15:0] etype,
                                             input logic [3:0] words, input logic [15:0] caplen);
        fmpf_in_t w;
        w = random_word();
        w.func = FUNC_CLASSIFY;
        w.protocol = proto;
        w.address = daddr;
        w.port = sport;
        w.ether_type = etype;
        w.header_words = words;
        w.captured_length = caplen;
        return w;
    endfunction

    function automatic fmpf_in_t random_rule();
        fmpf_in_t    w;
        logic [15:0] a;
        logic [15:0] b;
        w = random_word();
        w.func = FUNC_WRITE;
        if ($urandom_range(0, 9) < 7) w.rule_index = 9'($urandom_range(0, 31));
        case ($urandom_range(0, 4))
            0: w.protocol = PROTO_ANY;
            1: w.protocol = PROTO_TCP;
            2: w.protocol = PROTO_UDP;
            3: w.protocol = PROTO_ICMP;
            default: w.protocol = 8'($urandom);
        endcase
        if ($urandom_range(0, 3) == 0) w.address = '0;
        else w.address = addr_pool[$urandom_range(0, 7)];
        case ($urandom_range(0, 5))
            0: w.mask = 32'hFFFF_FFFF;
            1: w.mask = 32'hFFFF_FF00;
            2: w.mask = 32'hFFFF_0000;
            3: w.mask = 32'hFF00_0000;
            4: w.mask = '0;
            default: w.mask = $urandom;
        endcase
        if ($urandom_range(0, 6) != 0) begin
            w.rule_flags = RF_USED | RF_ENABLED | ($urandom_range(0, 1) ? RF_RANGE : RF_NONE)
                           | ($urandom_range(0, 1) ? RF_ACCEPT : RF_NONE);
        end
        a = port_pool[$urandom_range(0, 7)];
        b = port_pool[$urandom_range(0, 7)];
        if (w.rule_flags[2]) begin
            if ($urandom_range(0, 4) != 0 && a > b) begin
                w.port = b;
                w.port_high = a;
            end else begin
                w.port = a;
                w.port_high = b;
            end
        end else begin
            w.port = ($urandom_range(0, 4) < 2) ? 16'd0 : a;
        end
        return w;
    endfunction

    function automatic fmpf_in_t random_packet();
        fmpf_in_t    w;
        int unsigned l4_end;
        w = random_word();
        w.func = FUNC_CLASSIFY;
        w.ether_type = ETHERTYPE_IPV4;
        case ($urandom_range(0, 2))
            0: w.protocol = PROTO_TCP;
            1: w.protocol = PROTO_UDP;
            default: w.protocol = PROTO_ICMP;
        endcase
        w.address = addr_pool[$urandom_range(0, 7)];
        if ($urandom_range(0, 1)) w.address ^= $urandom_range(0, 255);
        if ($urandom_range(0, 2) != 0) w.port = port_pool[$urandom_range(0, 7)];
        if ($urandom_range(0, 4) != 0) w.header_words = 4'd5;
        l4_end = 4 * w.header_words + ((w.protocol == PROTO_TCP) ? ETH_TCP_LEN : ETH_UDP_LEN);
        if ($urandom_range(0, 5) == 0)
            w.captured_length = 16'(l4_end + $urandom_range(0, 2) - 1);
        else w.captured_length = 16'($urandom_range(34, 1518));
        return w;
    endfunction

    function automatic fmpf_in_t random_noise();
        fmpf_in_t w;
        w = random_word();
        if (w.func == FUNC_CLASSIFY && $urandom_range(0, 1)) w.ether_type = ETHERTYPE_IPV4;
        return w;
    endfunction

    task automatic test_unfiltered_paths();
        set_policy(1'b0);
        send_word(make_packet(PROTO_TCP, 32'h0A00_0001, 16'd1000, ETHERTYPE_IPV4, 4'd5, 16'd60));
        send_word(make_packet(PROTO_TCP, 32'h0A00_0001, 16'd1000, ETHERTYPE_IPV4, 4'd5, 16'd0));
        send_word(make_packet(PROTO_UDP, 32'h0A00_0001, 16'd53, ETHERTYPE_IPV4, 4'd5, 16'd13));
        send_word(make_packet(PROTO_ICMP, 32'h0A00_0001, 16'd0, ETHERTYPE_IPV4, 4'd5, 16'd33));
        send_word(make_packet(PROTO_TCP, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 4'd5, 16'hFFFF));
        send_word(make_packet(8'hFF, 32'h0A00_0001, 16'd80, ETHERTYPE_IPV4, 4'd5, 16'd1000));
        send_word(make_packet(PROTO_ANY, 32'h0A00_0001, 16'd80, ETHERTYPE_IPV4, 4'd5, 16'd1000));
        send_word(make_packet(PROTO_TCP, 32'h0A00_0001, 16'd80, ETHERTYPE_IPV4, 4'd15, 16'd93));
        send_word(make_packet(PROTO_TCP, 32'h0A00_0001, 16'd80, ETHERTYPE_IPV4, 4'd15, 16'd94));
        send_word(make_packet(PROTO_UDP, 32'h0A00_0001, 16'd53, ETHERTYPE_IPV4, 4'd5, 16'd41));
        send_word(make_packet(PROTO_UDP, 32'h0A00_0001, 16'd53, ETHERTYPE_IPV4, 4'd0, 16'd34));
    endtask

    task automatic test_rule_matching();
        // unused slot, inverted range, disabled rule, single port, full range at the top slot
        send_word(make_rule(9'd0, PROTO_ANY, '0, '0, '0, '0, RF_ENABLED | RF_RANGE | RF_ACCEPT));
        send_word(make_rule(9'd3, PROTO_ANY, '0, '0, 16'd500, 16'd100,
                            RF_USED | RF_ENABLED | RF_RANGE));
        send_word(make_rule(9'd5, PROTO_ANY, '0, '0, '0, '0, RF_USED | RF_ACCEPT));
        send_word(make_rule(9'd7, PROTO_UDP, 32'h0A00_0000, 32'hFF00_0000, 16'd80, '0,
                            RF_USED | RF_ENABLED | RF_ACCEPT));
        send_word(make_rule(9'd511, PROTO_TCP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd0, 16'hFFFF,
                            RF_USED | RF_ENABLED | RF_RANGE | RF_ACCEPT));
        send_word(make_packet(PROTO_UDP, 32'h0A01_0203, 16'd80, ETHERTYPE_IPV4, 4'd5, 16'd200));
        send_word(make_packet(PROTO_ICMP, '0, 16'd1234, ETHERTYPE_IPV4, 4'd5, 16'd98));
        send_word(make_packet(PROTO_TCP, 32'hFFFF_FFFF, 16'hFFFF, ETHERTYPE_IPV4, 4'd5,
                              16'd1518));
        send_word(make_packet(PROTO_UDP, 32'h0A01_0203, 16'd81, ETHERTYPE_IPV4, 4'd5, 16'd200));
    endtask

    task automatic test_default_policy();
        set_policy(1'b1);
        send_word(make_packet(PROTO_TCP, 32'h0102_0304, 16'd0, ETHERTYPE_IPV4, 4'd5, 16'd60));
        send_word(make_rule(9'd511, PROTO_TCP, '0, '0, '0, '0, RF_NONE));
        send_word(make_packet(PROTO_TCP, 32'hFFFF_FFFF, 16'd22, ETHERTYPE_IPV4, 4'd5, 16'd60));
    endtask

    task automatic test_random_traffic();
        int pick;
        int pause_at;
        addr_pool[0] = 32'hFFFF_FFFF;
        addr_pool[1] = '0;
        port_pool[0] = 16'd0;
        port_pool[1] = 16'd80;
        port_pool[2] = 16'd443;
        port_pool[3] = 16'd53;
        port_pool[4] = 16'hFFFF;
        for (int i = 2; i < 8; i++) addr_pool[i] = $urandom;
        for (int i = 5; i < 8; i++) port_pool[i] = 16'($urandom);
        for (int phase = 0; phase < 6; phase++) begin
            if (phase < 2) set_policy(phase[0]);
            else set_policy(1'($urandom_range(0, 1)));
            repeat (6) send_word(random_rule());
            pause_at = $urandom_range(20, 170);
            for (int n = 0; n < 189; n++) begin
                if (n == pause_at) drain_verdicts();
                pick = $urandom_range(0, 99);
                if (pick < 20) send_word(random_rule());
                else if (pick < 85) send_word(random_packet());
                else send_word(random_noise());
            end
        end
    endtask

    task automatic note_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%0t: %s mismatch: expected %0h, got %0h", $realtime, what, want, got);
    endtask

    // check each verdict word against the oldest prediction
    always @(negedge aclk) begin
        fmpf_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_verdicts.size() == 0) begin
                note_mismatch("unexpected verdict", '0, 32'(m_data));
            end else begin
                want = expected_verdicts.pop_front();
                if (m_data.drop !== want.drop)
                    note_mismatch("drop", 32'(want.drop), 32'(m_data.drop));
                if (m_data.decided_by !== want.decided_by)
                    note_mismatch("decided_by", 32'(want.decided_by), 32'(m_data.decided_by));
                if (m_data.matched_slot !== want.matched_slot)
                    note_mismatch("matched_slot", 32'(want.matched_slot),
                                  32'(m_data.matched_slot));
            end
        end
    end

    always @(posedge aclk) begin
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(20, 200);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= ($urandom_range(0, 3) != 0);
            2: m_ready <= ~m_ready;
            default: m_ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    always @(negedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $realtime, WATCHDOG_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        test_unfiltered_paths();
        test_rule_matching();
        test_default_policy();
        test_random_traffic();
        drain_verdicts();
        repeat (16) @(posedge aclk);
        if (expected_verdicts.size() != 0) note_mismatch("missing verdicts", '0, '0);
        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

### sim.f
design/fmpf_pkg.sv
design/fmpf_ram.sv
design/first_match_packet_filter.sv
tb/tb_first_match_packet_filter.sv
